// ===== src/ktaf_pkg.sv =====
// Shared types and constants for the tilt angle Kalman filter.
package ktaf_pkg;

  // Arithmetic opcodes issued by the sequencer to the serial datapath.
  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,  // Q product, rounded, saturated
    OP_DT   = 3'd1,  // value times step_ms over 1000, rounded, saturated
    OP_DIV  = 3'd2,  // Q quotient, rounded, saturated
    OP_ADD  = 3'd3,  // saturated sum
    OP_SUB  = 3'd4,  // saturated difference
    OP_SUB2 = 3'd5   // a minus b minus the old destination, saturated once
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;
  localparam logic [1:0] REG_H  = 2'd3;

  localparam int unsigned STEP_DIV = 1000;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Clamp a magnitude to 2^40 and apply a sign, then saturate.
  function automatic logic signed [31:0] signed_back(input logic [71:0] m, input logic neg);
    logic [71:0] c;
    logic signed [71:0] s;
    c = (m > 72'd1099511627776) ? 72'd1099511627776 : m;
    s = neg ? -$signed(c) : $signed(c);
    signed_back = sat32(s);
  endfunction

endpackage

// ===== src/kalman_tilt_angle_fusion.sv =====
// Top level: two-state tilt angle Kalman filter with a bit-serial datapath.
//
//   channel   signals                                    direction
//   -------   ----------------------------------------   ---------
//   input     in_valid/in_ready, gyro_rate, accel_angle,   in
//             step_ms
//   output    out_valid/out_ready, angle_estimate,         out
//             rate_estimate, bias_estimate
//   config    cfg_we, cfg_index, cfg_data                  in
//
// Each transaction runs a fixed list of 33 operations on one shared serial
// unit. A sum is a single step; a product is setup, one multiplier bit a cycle,
// then rounding; a step scaling is the product, then a 42-bit division by
// 1000; a quotient is setup, one quotient bit a cycle, then rounding.
// A zero innovation variance gives zero gains without a division.
// Reset clears the filter state to zero angle, zero bias, identity covariance.
// A finished result moves to the output register once that register is free;
// the next transaction is taken while the result waits there.
module kalman_tilt_angle_fusion
  import ktaf_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] gyro_rate,
  input  logic signed [31:0] accel_angle,
  input  logic        [9:0]  step_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] rate_estimate,
  output logic signed [31:0] bias_estimate,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic [30:0] RST_QA = 31'((64'd1 << FRAC_BITS) + 64'd500) / 31'd1000;
  localparam logic [30:0] RST_QB = 31'((64'd3 << FRAC_BITS) + 64'd500) / 31'd1000;
  localparam logic [30:0] RST_R  = 31'(64'd1 << (FRAC_BITS - 1));
  localparam int QBITS = 32 + FRAC_BITS;  // quotient bits produced serially
  localparam int DT_BITS = 42;            // bits of a product with step_ms

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // Register file slots used by the program.
  typedef enum logic [4:0] {
    R_ANG, R_BIAS, R_C00, R_C01, R_C10, R_C11, R_GYRO, R_ACC,
    R_QA, R_QB, R_RR, R_H, R_T0, R_T1, R_D0, R_D1, R_PC0, R_PC1,
    R_E, R_K0, R_K1, R_ERR, R_RATE, R_ZERO
  } slot_t;

  typedef struct packed {
    op_t   op;
    slot_t a;
    slot_t b;
    slot_t d;
  } instr_t;

  localparam int NPROG = 36;

  // Fixed program that mirrors one filter step.
  function automatic instr_t prog(input logic [5:0] pc);
    instr_t i;
    i = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
    case (pc)
      6'd0:  i = '{OP_SUB, R_GYRO, R_BIAS, R_T0};
      6'd1:  i = '{OP_DT,  R_T0,   R_ZERO, R_T0};
      6'd2:  i = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
      6'd3:  i = '{OP_ADD, R_C10,  R_ZERO, R_D0};
      6'd4:  i = '{OP_SUB2, R_QA,  R_C01,  R_D0};
      6'd5:  i = '{OP_SUB, R_ZERO, R_C11,  R_D1};
      6'd6:  i = '{OP_DT,  R_D0,   R_ZERO, R_T0};
      6'd7:  i = '{OP_ADD, R_C00,  R_T0,   R_C00};
      6'd8:  i = '{OP_DT,  R_D1,   R_ZERO, R_T0};
      6'd9:  i = '{OP_ADD, R_C01,  R_T0,   R_C01};
      6'd10: i = '{OP_ADD, R_C10,  R_T0,   R_C10};
      6'd11: i = '{OP_DT,  R_QB,   R_ZERO, R_T0};
      6'd12: i = '{OP_ADD, R_C11,  R_T0,   R_C11};
      6'd13: i = '{OP_MUL, R_H,    R_C00,  R_PC0};
      6'd14: i = '{OP_MUL, R_H,    R_C01,  R_PC1};
      6'd15: i = '{OP_MUL, R_H,    R_PC0,  R_T0};
      6'd16: i = '{OP_ADD, R_RR,   R_T0,   R_E};
      6'd17: i = '{OP_DIV, R_PC0,  R_E,    R_K0};
      6'd18: i = '{OP_DIV, R_PC1,  R_E,    R_K1};
      6'd19: i = '{OP_SUB, R_ACC,  R_ANG,  R_ERR};
      6'd20: i = '{OP_MUL, R_K0,   R_ERR,  R_T0};
      6'd21: i = '{OP_ADD, R_ANG,  R_T0,   R_ANG};
      6'd22: i = '{OP_MUL, R_K1,   R_ERR,  R_T0};
      6'd23: i = '{OP_ADD, R_BIAS, R_T0,   R_BIAS};
      6'd24: i = '{OP_SUB, R_GYRO, R_BIAS, R_RATE};
      6'd25: i = '{OP_MUL, R_K0,   R_PC0,  R_T0};
      6'd26: i = '{OP_SUB, R_C00,  R_T0,   R_C00};
      6'd27: i = '{OP_MUL, R_K0,   R_PC1,  R_T0};
      6'd28: i = '{OP_SUB, R_C01,  R_T0,   R_C01};
      6'd29: i = '{OP_MUL, R_K1,   R_PC0,  R_T0};
      6'd30: i = '{OP_SUB, R_C10,  R_T0,   R_C10};
      6'd31: i = '{OP_MUL, R_K1,   R_PC1,  R_T0};
      6'd32: i = '{OP_SUB, R_C11,  R_T0,   R_C11};
      default: i = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return i;
  endfunction

  state_t state;
  logic [5:0] pc;
  logic [6:0] cnt;
  logic       busy;       // a multi-cycle operation is under way
  logic       fin;        // reduction phase of a multi-cycle operation
  logic       dtdiv;      // step scaling is in its division by 1000
  logic       load_out;   // finished result moves to the output register
  logic signed [31:0] rf [0:23];
  logic [9:0] ms;

  // Serial datapath registers.
  logic [71:0] acc;       // product accumulator or partial remainder
  logic [31:0] mplr;      // multiplier magnitude shifted out one bit a cycle
  logic [71:0] mcnd;      // multiplicand magnitude
  logic [71:0] dvsr;      // divisor magnitude
  logic [71:0] num;       // dividend magnitude shifted out one bit a cycle
  logic [71:0] quo;
  logic        neg;
  logic [71:0] red;       // magnitude after rounding shift

  instr_t ins;
  logic signed [31:0] va, vb, vd;
  logic [31:0] ma, mb;

  assign ins = prog(pc);
  assign va  = rf[ins.a];
  assign vb  = rf[ins.b];
  assign vd  = rf[ins.d];
  assign ma  = va[31] ? 32'(-va) : 32'(va);
  assign mb  = vb[31] ? 32'(-vb) : 32'(vb);

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  // Output register: a finished result waits here for its transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      angle_estimate <= '0;
      rate_estimate  <= '0;
      bias_estimate  <= '0;
    end else if (load_out) begin
      out_valid      <= 1'b1;
      angle_estimate <= rf[R_ANG];
      rate_estimate  <= rf[R_RATE];
      bias_estimate  <= rf[R_BIAS];
    end else if (out_ready) begin
      out_valid      <= 1'b0;
    end
  end

  // Configuration registers, sequencer and serial arithmetic.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf[R_QA] <= {1'b0, RST_QA};
      rf[R_QB] <= {1'b0, RST_QB};
      rf[R_RR] <= {1'b0, RST_R};
      rf[R_H]  <= ONE_Q;
      state <= S_IDLE;
      pc <= '0;
      cnt <= '0;
      busy <= 1'b0;
      fin <= 1'b0;
      dtdiv <= 1'b0;
      rf[R_ANG] <= '0;
      rf[R_BIAS] <= '0;
      rf[R_C00] <= ONE_Q;
      rf[R_C01] <= '0;
      rf[R_C10] <= '0;
      rf[R_C11] <= ONE_Q;
      rf[R_ZERO] <= '0;
      rf[R_RATE] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_QA: rf[R_QA] <= {1'b0, cfg_data[30:0]};
          REG_QB: rf[R_QB] <= {1'b0, cfg_data[30:0]};
          REG_R:  rf[R_RR] <= {1'b0, cfg_data[30:0]};
          REG_H:  rf[R_H]  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rf[R_GYRO] <= gyro_rate;
            rf[R_ACC]  <= accel_angle;
            ms    <= step_ms;
            pc    <= '0;
            busy  <= 1'b0;
            fin   <= 1'b0;
            dtdiv <= 1'b0;
            state <= S_RUN;
          end
        end
        S_LOAD: state <= S_RUN;
        S_RUN: begin
          if (!busy) begin
            unique case (ins.op) inside
              OP_ADD: begin
                rf[ins.d] <= sat32(72'(va) + 72'(vb));
                pc <= pc + 6'd1;
              end
              OP_SUB: begin
                rf[ins.d] <= sat32(72'(va) - 72'(vb));
                pc <= pc + 6'd1;
              end
              OP_SUB2: begin
                rf[ins.d] <= sat32(72'(va) - 72'(vb) - 72'(vd));
                pc <= pc + 6'd1;
              end
              OP_MUL, OP_DT: begin
                acc  <= '0;
                mcnd <= 72'(ma);
                mplr <= (ins.op == OP_DT) ? 32'(ms) : mb;
                neg  <= (ins.op == OP_DT) ? (va[31] && ms != 10'd0)
                                          : (va[31] ^ vb[31]) && va != 0 && vb != 0;
                cnt  <= 7'd32;
                busy <= 1'b1;
                fin  <= 1'b0;
              end
              OP_DIV: begin
                if (vb == 0) begin
                  rf[ins.d] <= '0;
                  pc <= pc + 6'd1;
                end else begin
                  acc  <= '0;
                  num  <= 72'(ma) << (72 - 32 - FRAC_BITS + FRAC_BITS) ;
                  dvsr <= 72'(mb);
                  quo  <= '0;
                  neg  <= (va[31] != vb[31]) && va != 0;
                  cnt  <= 7'(QBITS);
                  busy <= 1'b1;
                  fin  <= 1'b0;
                end
              end
              default: pc <= pc + 6'd1;
            endcase
          end else if (ins.op == OP_DIV || dtdiv) begin
            // Restoring division, one quotient bit a cycle.
            if (cnt != 0) begin
              if ({acc[70:0], num[71]} >= dvsr) begin
                acc <= {acc[70:0], num[71]} - dvsr;
                quo <= {quo[70:0], 1'b1};
              end else begin
                acc <= {acc[70:0], num[71]};
                quo <= {quo[70:0], 1'b0};
              end
              num <= {num[70:0], 1'b0};
              cnt <= cnt - 7'd1;
            end else begin
              if (dtdiv) begin
                // Rounding was added to the dividend before the division.
                rf[ins.d] <= signed_back(quo, neg);
                dtdiv <= 1'b0;
              end else begin
                // Round half up: remainder twice compared with divisor.
                rf[ins.d] <= signed_back(quo + 72'(({acc[70:0], 1'b0} >= dvsr) ? 1 : 0),
                                         neg);
              end
              busy <= 1'b0;
              pc <= pc + 6'd1;
            end
          end else begin
            // Shift-add multiply, one multiplier bit a cycle.
            if (cnt != 0) begin
              if (mplr[0]) acc <= acc + mcnd;
              mcnd <= {mcnd[70:0], 1'b0};
              mplr <= {1'b0, mplr[31:1]};
              cnt <= cnt - 7'd1;
            end else if (!fin) begin
              if (ins.op == OP_DT) begin
                // Rounded division of the product by 1000, one bit a cycle.
                num   <= (acc + 72'd500) << (72 - DT_BITS);
                dvsr  <= 72'(STEP_DIV);
                acc   <= '0;
                quo   <= '0;
                cnt   <= 7'(DT_BITS);
                dtdiv <= 1'b1;
              end else begin
                red <= (acc + (72'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                fin <= 1'b1;
              end
            end else begin
              rf[ins.d] <= signed_back(red, neg);
              busy <= 1'b0;
              fin <= 1'b0;
              pc <= pc + 6'd1;
            end
          end
          if (!busy && pc == 6'(NPROG - 3)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Handshake and sequencing checks.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid) else $error("finished result not presented");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_estimate))
    else $error("result dropped before transaction");
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_RUN && pc == 6'd0)
    else $error("program did not restart");

endmodule

// ===== tb/kalman_tilt_angle_fusion_tb.sv =====
// Testbench for the tilt angle Kalman filter: directed and random traffic, predictor scoreboard.
module kalman_tilt_angle_fusion_tb
  import ktaf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 20;

  typedef struct {
    int angle;
    int rate;
    int bias;
  } estimate_t;

  // This class holds the filter state and the expected estimates in order.
  class tilt_filter_scoreboard;
    int angle_st, bias_st, p00, p01, p10, p11;
    int qa, qb, rn, hg;
    estimate_t pending_estimates[$];
    int mismatches;

    function new();
      angle_st = 0;
      bias_st = 0;
      p00 = 1 << FRAC;
      p01 = 0;
      p10 = 0;
      p11 = 1 << FRAC;
      qa = 1049;
      qb = 3146;
      rn = 524288;
      hg = 1 << FRAC;
      mismatches = 0;
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // Clamp a magnitude, apply the sign and saturate.
    function int signed_mag(longint unsigned m, bit neg);
      longint unsigned lim;
      lim = 64'd1 << 40;
      if (m > lim) m = lim;
      return sat(neg ? -longint'(m) : longint'(m));
    endfunction

    function longint unsigned mag(longint p);
      return (p < 0) ? longint'(-p) : p;
    endfunction

    function int qmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return signed_mag((mag(p) + (64'd1 << (FRAC - 1))) >> FRAC, p < 0);
    endfunction

    function int times_step(int x, bit [9:0] ms);
      longint p;
      p = longint'(x) * longint'({22'd0, ms});
      return signed_mag((mag(p) + 500) / STEP_DIV, p < 0);
    endfunction

    function int qdiv(int n, int d);
      longint unsigned mn, md;
      if (d == 0) return 0;
      mn = mag(longint'(n));
      md = mag(longint'(d));
      return signed_mag(((mn << FRAC) + md / 2) / md, (n < 0) != (d < 0));
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_QA: qa = int'({1'b0, data[30:0]});
        REG_QB: qb = int'({1'b0, data[30:0]});
        REG_R: rn = int'({1'b0, data[30:0]});
        default: hg = int'(data);
      endcase
    endfunction

    // Predict, update the covariance, correct, and queue the estimate.
    function void note_sample(int gyro, int accel, bit [9:0] ms);
      int d0, d1, pc0, pc1, e, k0, k1, err, t1;
      estimate_t x;
      angle_st = sat(longint'(angle_st) + times_step(sat(longint'(gyro) - bias_st), ms));
      d0 = sat(longint'(qa) - p01 - p10);
      d1 = sat(-longint'(p11));
      p00 = sat(longint'(p00) + times_step(d0, ms));
      p01 = sat(longint'(p01) + times_step(d1, ms));
      p10 = sat(longint'(p10) + times_step(d1, ms));
      p11 = sat(longint'(p11) + times_step(qb, ms));
      pc0 = qmul(hg, p00);
      pc1 = qmul(hg, p01);
      e = sat(longint'(rn) + qmul(hg, pc0));
      k0 = qdiv(pc0, e);
      k1 = qdiv(pc1, e);
      err = sat(longint'(accel) - angle_st);
      angle_st = sat(longint'(angle_st) + qmul(k0, err));
      bias_st = sat(longint'(bias_st) + qmul(k1, err));
      x.angle = angle_st;
      x.rate = sat(longint'(gyro) - bias_st);
      x.bias = bias_st;
      t1 = qmul(hg, p01);
      p00 = sat(longint'(p00) - qmul(k0, pc0));
      p01 = sat(longint'(p01) - qmul(k0, t1));
      p10 = sat(longint'(p10) - qmul(k1, pc0));
      p11 = sat(longint'(p11) - qmul(k1, t1));
      pending_estimates.push_back(x);
    endfunction

    function void check_result(int angle, int rate, int bias);
      estimate_t x;
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no pending estimate: %0d %0d %0d",
                                       angle, rate, bias);
        return;
      end
      x = pending_estimates.pop_front();
      if (x.angle !== angle || x.rate !== rate || x.bias !== bias) begin
        mismatches++;
        if (mismatches <= 10)
          $display("estimate mismatch: angle %0d/%0d rate %0d/%0d bias %0d/%0d (exp/act)",
                   x.angle, angle, x.rate, rate, x.bias, bias);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  logic signed [31:0] gyro_rate, accel_angle;
  logic [9:0] step_ms;
  logic signed [31:0] angle_estimate, rate_estimate, bias_estimate;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int sender_idle, receiver_stall;

  tilt_filter_scoreboard board = new();

  kalman_tilt_angle_fusion u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: random back-pressure, results checked where they are stable.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(angle_estimate, rate_estimate, bias_estimate);
  end

  // Send one sample; valid stays high from the previous sample when no gap is taken.
  task automatic send_sample(int gyro, int accel, bit [9:0] ms);
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_valid <= 1'b1;
    gyro_rate <= gyro;
    accel_angle <= accel;
    step_ms <= ms;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    board.note_sample(gyro, accel, ms);
    @(posedge clk);
  endtask

  // Configuration is written only once the filter is idle.
  task automatic write_config(int unsigned qa, int unsigned qb, int unsigned rn, int hg);
    logic [31:0] vals[4];
    vals = '{qa, qb, rn, hg};
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_estimates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      board.write_reg(i[1:0], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_value();
    int k;
    k = $urandom_range(9);
    if (k < 6) return $signed($urandom_range(200 << FRAC)) - (100 << FRAC);
    if (k < 8) return $urandom();
    return $signed($urandom_range(2000)) - 1000;
  endfunction

  function automatic bit [9:0] pick_step();
    if ($urandom_range(9) < 8) return 10'($urandom_range(20));
    return 10'($urandom_range(1023));
  endfunction

  initial begin
    int cfg_sets[8][4];
    int idle_modes[4][2];
    rst <= 1'b1;
    in_valid <= 1'b0;
    gyro_rate <= '0;
    accel_angle <= '0;
    step_ms <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_QA;
    cfg_data <= '0;
    sender_idle = 0;
    receiver_stall = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples: field extremes, zero step and steps past one second.
    send_sample(0, 0, 0);
    send_sample(32'sh7fffffff, 32'sh7fffffff, 1000);
    send_sample(32'sh80000000, 32'sh80000000, 1023);
    send_sample(32'sh7fffffff, 32'sh80000000, 1001);
    send_sample(32'sh80000000, 32'sh7fffffff, 0);
    send_sample(1 << FRAC, 45 << FRAC, 10);
    send_sample(-(1 << FRAC), -(45 << FRAC), 5);
    send_sample(-1, 1, 1);
    send_sample(32'sh55555555, 32'shaaaaaaaa, 10'h155);
    send_sample(32'shaaaaaaaa, 32'sh55555555, 10'h2aa);
    send_sample(0, 0, 1023);
    send_sample(0, 0, 1000);

    // Register settings: defaults, both extremes, zero observation gain, random.
    cfg_sets[0] = '{1049, 3146, 524288, 1 << FRAC};
    cfg_sets[1] = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'sh7fffffff};
    cfg_sets[2] = '{0, 0, 1, 32'sh80000000};
    cfg_sets[3] = '{1049, 3146, 1, 0};
    cfg_sets[4] = '{1, 1, 1, -(1 << FRAC)};
    cfg_sets[5] = '{$urandom_range(1 << 20), $urandom_range(1 << 20),
                    $urandom_range(1 << 22, 1), $urandom()};
    cfg_sets[6] = '{$urandom() >> 1, $urandom() >> 1, ($urandom() >> 1) | 1, $urandom()};
    cfg_sets[7] = '{1049, 3146, 524288, 1 << FRAC};
    idle_modes = '{'{0, 0}, '{70, 0}, '{0, 70}, '{22, 22}};

    for (int p = 0; p < 8; p++) begin
      write_config(cfg_sets[p][0], cfg_sets[p][1], cfg_sets[p][2], cfg_sets[p][3]);
      sender_idle = idle_modes[p % 4][0];
      receiver_stall = idle_modes[p % 4][1];
      repeat (61) send_sample(pick_value(), pick_value(), pick_step());
    end
    in_valid <= 1'b0;

    while (board.pending_estimates.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (board.mismatches == 0 && board.pending_estimates.size() == 0) begin
      $display("kalman_tilt_angle_fusion regression: pass");
    end else begin
      $display("kalman_tilt_angle_fusion regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40000000;
    $display("kalman_tilt_angle_fusion regression: fail");
    $finish;
  end

endmodule
